/* hdl/ezr_pkg.sv */
// ============================================================================
// ezr_pkg: shared types and constants for the Euler ZYX rotation matrix block
// CORDIC gain, fold limits and arctangent table at 32 fractional bits.
// ============================================================================
package ezr_pkg;

  localparam int AccW = 36;  // Q3.32 plus headroom
  localparam int TableLen = 31;

  localparam logic signed [AccW-1:0] PiQ32     = 36'sd13493037705;
  localparam logic signed [AccW-1:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic signed [AccW-1:0] GainQ32   = 36'sd2608131496;

  typedef logic signed [AccW-1:0] acc_t;

  // one CORDIC lane: rotation vector, residual angle, fold flag
  typedef struct packed {
    acc_t x;
    acc_t y;
    acc_t z;
    logic neg;
  } lane_t;

  function automatic acc_t atan_q32(input int i);
    acc_t r;
    r = '0;
    case (i)
      0: r = 36'sd3373259426;   1: r = 36'sd1991351318;
      2: r = 36'sd1052175346;   3: r = 36'sd534100635;
      4: r = 36'sd268086748;    5: r = 36'sd134174063;
      6: r = 36'sd67103403;     7: r = 36'sd33553749;
      8: r = 36'sd16777131;     9: r = 36'sd8388597;
      10: r = 36'sd4194303;     11: r = 36'sd2097152;
      12: r = 36'sd1048576;     13: r = 36'sd524288;
      14: r = 36'sd262144;      15: r = 36'sd131072;
      16: r = 36'sd65536;       17: r = 36'sd32768;
      18: r = 36'sd16384;       19: r = 36'sd8192;
      20: r = 36'sd4096;        21: r = 36'sd2048;
      22: r = 36'sd1024;        23: r = 36'sd512;
      24: r = 36'sd256;         25: r = 36'sd128;
      26: r = 36'sd64;          27: r = 36'sd32;
      28: r = 36'sd16;          29: r = 36'sd8;
      30: r = 36'sd4;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/ezr_cell.sv */
// ============================================================================
// ezr_cell: one CORDIC micro-rotation cell for three angle lanes
// Registers the rotated lanes when the chain advances.
// ============================================================================
module ezr_cell import ezr_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_in  [3],
  output lane_t lane_out [3]
);

  localparam acc_t Step = atan_q32(Stage);

  lane_t lane_next [3];

  // rotate each lane toward zero residual angle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_next[k].neg = lane_in[k].neg;
      if (Stage >= TableLen) begin
        lane_next[k] = lane_in[k];
      end else if (!lane_in[k].z[AccW-1]) begin
        lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> Stage);
        lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> Stage);
        lane_next[k].z = lane_in[k].z - Step;
      end else begin
        lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> Stage);
        lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> Stage);
        lane_next[k].z = lane_in[k].z + Step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

/* hdl/euler_zyx_to_rotation_matrix.sv */
// ============================================================================
// euler_zyx_to_rotation_matrix: Euler ZYX angles to 3x3 rotation matrix
// CORDIC cell chain for sin/cos, then a registered product pipeline.
// ============================================================================
//  channel | signals                                  | beat
//  in      | in_valid in_ready yaw/pitch/roll_angle   | three angles Q2.F
//  out     | out_valid out_ready m00 .. m22           | nine elements Q1.F
//
// One beat per cycle sustained while out_ready is high. CORDIC_STAGES + 5
// register stages: one fold stage, one cell per CORDIC stage, a rounding stage,
// three product stages. The pipeline advances as a whole; the output register
// stalls it only when a result waits and out_ready is low. Reset clears valid
// bits.
module euler_zyx_to_rotation_matrix import ezr_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FRAC_BITS+2:0] yaw_angle,
  input  logic signed [FRAC_BITS+2:0] pitch_angle,
  input  logic signed [FRAC_BITS+2:0] roll_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] m00,
  output logic signed [FRAC_BITS+1:0] m01,
  output logic signed [FRAC_BITS+1:0] m02,
  output logic signed [FRAC_BITS+1:0] m10,
  output logic signed [FRAC_BITS+1:0] m11,
  output logic signed [FRAC_BITS+1:0] m12,
  output logic signed [FRAC_BITS+1:0] m20,
  output logic signed [FRAC_BITS+1:0] m21,
  output logic signed [FRAC_BITS+1:0] m22
);

  localparam int InW   = FRAC_BITS + 3;
  localparam int OutW  = FRAC_BITS + 2;
  localparam int Shift = 32 - FRAC_BITS;
  localparam int PW    = 2 * OutW;
  localparam int Depth = CORDIC_STAGES + 5;
  localparam acc_t PiQ  = acc_t'((PiQ32 + (acc_t'(1) <<< (Shift - 1))) >>> Shift);
  localparam logic signed [OutW-1:0] One  = OutW'(1) << FRAC_BITS;
  localparam logic signed [OutW+1:0] OneW = (OutW+2)'(1) << FRAC_BITS;

  typedef logic signed [OutW-1:0] q_t;
  typedef logic signed [OutW+1:0] qw_t;

  logic [Depth-1:0] vld;
  logic             adv;

  // whole chain moves unless a finished result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end
  assign out_valid = vld[Depth-1];

  function automatic acc_t clamp_q32(input logic signed [InW-1:0] a);
    acc_t v;
    v = acc_t'(a);
    if (v > PiQ) v = PiQ;
    if (v < -PiQ) v = -PiQ;
    return v <<< Shift;
  endfunction

  function automatic q_t round_sat(input acc_t v);
    acc_t r;
    r = (v + (acc_t'(1) <<< (Shift - 1))) >>> Shift;
    if (r > acc_t'(One)) r = acc_t'(One);
    if (r < -acc_t'(One)) r = -acc_t'(One);
    return q_t'(r);
  endfunction

  function automatic q_t fmul(input q_t a, input q_t b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b)) + (PW'(1) <<< (FRAC_BITS - 1));
    return q_t'(p >>> FRAC_BITS);
  endfunction

  function automatic q_t sat_w(input qw_t v);
    qw_t r;
    r = v;
    if (r > OneW) r = OneW;
    if (r < -OneW) r = -OneW;
    return q_t'(r);
  endfunction

  // fold stage: clamp, fold to [-pi/2, pi/2], seed the lanes
  lane_t chain [CORDIC_STAGES+1][3];
  logic signed [InW-1:0] ang [3];
  assign ang[0] = yaw_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = roll_angle;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        chain[0][k].x   <= GainQ32;
        chain[0][k].y   <= '0;
        if (clamp_q32(ang[k]) > HalfPiQ32) begin
          chain[0][k].z   <= clamp_q32(ang[k]) - PiQ32;
          chain[0][k].neg <= 1'b1;
        end else if (clamp_q32(ang[k]) < -HalfPiQ32) begin
          chain[0][k].z   <= clamp_q32(ang[k]) + PiQ32;
          chain[0][k].neg <= 1'b1;
        end else begin
          chain[0][k].z   <= clamp_q32(ang[k]);
          chain[0][k].neg <= 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ezr_cell #(.Stage(g)) u_cell (
      .clk     (clk),
      .en      (adv),
      .lane_in (chain[g]),
      .lane_out(chain[g+1])
    );
  end

  // round to Q.F, saturate, then undo fold
  q_t sn [3];
  q_t cs [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (chain[CORDIC_STAGES][k].neg) begin
          sn[k] <= -round_sat(chain[CORDIC_STAGES][k].y);
          cs[k] <= -round_sat(chain[CORDIC_STAGES][k].x);
        end else begin
          sn[k] <= round_sat(chain[CORDIC_STAGES][k].y);
          cs[k] <= round_sat(chain[CORDIC_STAGES][k].x);
        end
      end
    end
  end

  // product stage 1: pair products
  q_t czsy, szsy, czcy, szcx, szsx, czcx, czsx, szcy, cycx, cysx, nsy;
  q_t p_sx, p_cx;
  always_ff @(posedge clk) begin
    if (adv) begin
      czsy <= fmul(cs[0], sn[1]);
      szsy <= fmul(sn[0], sn[1]);
      czcy <= fmul(cs[0], cs[1]);
      szcx <= fmul(sn[0], cs[2]);
      szsx <= fmul(sn[0], sn[2]);
      czcx <= fmul(cs[0], cs[2]);
      czsx <= fmul(cs[0], sn[2]);
      szcy <= fmul(sn[0], cs[1]);
      cycx <= fmul(cs[1], cs[2]);
      cysx <= fmul(cs[1], sn[2]);
      nsy  <= -sn[1];
      p_sx <= sn[2];
      p_cx <= cs[2];
    end
  end

  // product stage 2: three-factor terms
  q_t t01, t02, t11, t12;
  q_t d00, d10, d20, d21, d22, e01, e02, e11, e12;
  always_ff @(posedge clk) begin
    if (adv) begin
      t01 <= fmul(czsy, p_sx);
      t02 <= fmul(czsy, p_cx);
      t11 <= fmul(szsy, p_sx);
      t12 <= fmul(szsy, p_cx);
      e01 <= szcx; e02 <= szsx; e11 <= czcx; e12 <= czsx;
      d00 <= czcy; d10 <= szcy; d20 <= nsy; d21 <= cysx; d22 <= cycx;
    end
  end

  // output register: sums and saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      m00 <= d00;
      m01 <= sat_w(qw_t'(t01) - qw_t'(e01));
      m02 <= sat_w(qw_t'(t02) + qw_t'(e02));
      m10 <= d10;
      m11 <= sat_w(qw_t'(t11) + qw_t'(e11));
      m12 <= sat_w(qw_t'(t12) - qw_t'(e12));
      m20 <= d20;
      m21 <= d21;
      m22 <= d22;
    end
  end

  // a held result must stay valid until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(m00) && $stable(m22))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready not tied to output register");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m00 <= One) && (m00 >= -One))
    else $error("element out of range");

endmodule
